// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the tone sequencer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tss_pkg.sv
// Shared types, constants and lookup functions of the tone sample sequencer.
// Depends on nothing; used by every RTL module of the block.
package tss_pkg;

   localparam int INDEX_WIDTH  = 24;
   localparam int SINE_ENTRIES = 256;
   localparam int NOTE_COUNT   = 8;

   localparam int RATE_W      = 17;
   localparam int COUNT_W     = 24;
   localparam int CSR_W       = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int OP_W        = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int STATUS_W    = 2;
   localparam int SAMPLE_W    = 8;
   localparam int INTERVAL_W  = 18;
   localparam int RSP_W       = 32;

   localparam int PHASE_W     = $clog2(SINE_ENTRIES);
   localparam int NOTE_W      = $clog2(NOTE_COUNT);
   localparam int FREQ_W      = 10;
   localparam int POS_W       = RATE_W - 2;
   localparam int PROD_W      = POS_W + FREQ_W;
   localparam int DIV_W       = PROD_W + PHASE_W;
   localparam int REM_W       = RATE_W;
   localparam int PHASE_ITERS = DIV_W - REM_W;
   localparam int US_W        = 20;
   localparam int ITER_W      = $clog2(DIV_W + 1);
   localparam int CMP_W       = (INDEX_WIDTH + 1 > COUNT_W) ? INDEX_WIDTH + 1 : COUNT_W;

   localparam logic [RATE_W-1:0]     RATE_RESET   = RATE_W'(16000);
   localparam logic [COUNT_W-1:0]    COUNT_RESET  = COUNT_W'(32000);
   localparam logic [US_W-1:0]       US_PER_S     = US_W'(1000000);
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};
   localparam logic [SAMPLE_W-1:0]   SINE_MID     = SAMPLE_W'(128);

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RATE  = 1'b0,
      REG_COUNT = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      DIV_NOTE  = 2'd0,
      DIV_PHASE = 2'd1,
      DIV_INTV  = 2'd2
   } div_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         accept;
      logic         div_start;
      div_kind_type div_kind;
      logic         mul_load;
      logic         sample_load;
      logic         interval_load;
      logic         out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic run_tick;
      logic div_busy;
   } stat_type;

   localparam logic [6:0] QUARTER_WAVE [0:64] = '{
      7'd0,  7'd2,  7'd4,  7'd7,  7'd9,  7'd11, 7'd13, 7'd15,
      7'd18, 7'd20, 7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32,
      7'd34, 7'd36, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46, 7'd48,
      7'd50, 7'd52, 7'd54, 7'd55, 7'd57, 7'd59, 7'd60, 7'd62,
      7'd64, 7'd65, 7'd67, 7'd68, 7'd70, 7'd71, 7'd72, 7'd74,
      7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
      7'd83, 7'd84, 7'd85, 7'd85, 7'd86, 7'd87, 7'd87, 7'd88,
      7'd88, 7'd89, 7'd89, 7'd89, 7'd90, 7'd90, 7'd90, 7'd90,
      7'd90
   };

   localparam logic [FREQ_W-1:0] NOTE_HZ [0:NOTE_COUNT-1] = '{
      10'd500, 10'd600, 10'd700, 10'd800, 10'd700, 10'd600, 10'd500, 10'd0
   };

   // Full sine period rebuilt from the quarter wave by mirroring.
   function automatic logic [SAMPLE_W-1:0] sine_value(input logic [PHASE_W-1:0] k);
      logic [6:0] m;
      logic [7:0] mirror;
      logic [6:0] v;
      m      = k[6:0];
      mirror = 8'd128 - {1'b0, m};
      v      = (m <= 7'd64) ? QUARTER_WAVE[m] : QUARTER_WAVE[mirror[6:0]];
      return k[PHASE_W-1] ? (SINE_MID - {1'b0, v}) : (SINE_MID + {1'b0, v});
   endfunction

endpackage

// File: hw/rtl/tss_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by all divisions.
// Depends on tss_pkg for the operand widths.
module tss_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tss_pkg::ITER_W-1:0]  iters,
   input  logic [tss_pkg::REM_W-1:0]   rem_init,
   input  logic [tss_pkg::DIV_W-1:0]   dvd_init,
   input  logic [tss_pkg::REM_W-1:0]   divisor,
   output logic                        busy,
   output logic [tss_pkg::DIV_W-1:0]   quot,
   output logic [tss_pkg::REM_W-1:0]   rem
);
   import tss_pkg::*;

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;
   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;
   logic              fits;

   // The quotient shifts in at the bottom while the dividend leaves at the top.
   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = rem_init;
         dvd_in  = dvd_init;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy = busy_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

// File: hw/rtl/tss_datapath.sv
// Datapath of the tone sequencer: settings, play state, multiplier, result registers.
// Depends on tss_pkg and instantiates the serial divider tss_div.
module tss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tss_pkg::cmd_type              cmd,
   output tss_pkg::stat_type             stat,
   input  logic [tss_pkg::OP_W-1:0]      req_op,
   input  logic                          req_loop,
   input  logic                          csr_we,
   input  logic [tss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_W-1:0]     csr_wdata,
   output logic [tss_pkg::RSP_W-1:0]     rsp_data
);
   import tss_pkg::*;

   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic                   running_ff, running_in;
   logic                   loop_ff, loop_in;
   logic                   acc_ff, acc_in;
   status_type             status_ff, status_in;
   logic [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [RSP_W-1:0]       out_ff, out_in;

   op_type                 op;
   logic                   start_ok;
   logic [CMP_W-1:0]       next_wide;
   logic                   clip_end;
   logic [POS_W-1:0]       spn;
   logic [DIV_W-1:0]       ph_full;
   logic [ITER_W-1:0]      div_iters;
   logic [REM_W-1:0]       div_rem_init;
   logic [DIV_W-1:0]       div_dvd_init;
   logic [REM_W-1:0]       div_divisor;
   logic                   div_busy;
   logic [DIV_W-1:0]       div_quot;
   logic [REM_W-1:0]       div_rem;
   logic [FREQ_W-1:0]      freq;
   logic [US_W-1:0]        us_quot;

   assign op        = op_type'(req_op);
   assign start_ok  = (count_ff != '0) && (rate_ff != '0);
   assign next_wide = CMP_W'(index_ff) + CMP_W'(1);
   assign clip_end  = (next_wide >= CMP_W'(count_ff));

   // A note lasts a quarter of the rate in samples, but never less than one.
   assign spn     = (rate_ff[RATE_W-1:2] == '0) ? POS_W'(1) : rate_ff[RATE_W-1:2];
   assign ph_full = {prod_ff, {PHASE_W{1'b0}}};

   always_comb begin
      case (cmd.div_kind)
         DIV_PHASE: begin
            // The phase quotient fits in PHASE_ITERS bits, so the top part preloads.
            div_iters    = ITER_W'(PHASE_ITERS);
            div_rem_init = ph_full[DIV_W-1:PHASE_ITERS];
            div_dvd_init = {ph_full[PHASE_ITERS-1:0], {(DIV_W-PHASE_ITERS){1'b0}}};
            div_divisor  = rate_ff;
         end
         DIV_INTV: begin
            div_iters    = ITER_W'(US_W);
            div_rem_init = '0;
            div_dvd_init = {US_PER_S, {(DIV_W-US_W){1'b0}}};
            div_divisor  = rate_ff;
         end
         default: begin
            div_iters    = ITER_W'(INDEX_WIDTH);
            div_rem_init = '0;
            div_dvd_init = {index_ff, {(DIV_W-INDEX_WIDTH){1'b0}}};
            div_divisor  = REM_W'(spn);
         end
      endcase
   end

   tss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .iters    (div_iters),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign freq    = NOTE_HZ[div_quot[NOTE_W-1:0]];
   assign us_quot = div_quot[US_W-1:0];

   always_comb begin
      rate_in     = rate_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      running_in  = running_ff;
      loop_in     = loop_ff;
      acc_in      = acc_ff;
      status_in   = status_ff;
      sample_in   = sample_ff;
      interval_in = interval_ff;
      prod_in     = prod_ff;
      out_in      = out_ff;

      if (cmd.accept) begin
         sample_in   = '0;
         interval_in = '0;
         case (op)
            OP_START: begin
               acc_in    = start_ok;
               status_in = (start_ok || running_ff) ? ST_RUN : ST_IDLE;
               if (start_ok) begin
                  index_in   = '0;
                  loop_in    = req_loop;
                  running_in = 1'b1;
               end
            end
            OP_STOP: begin
               acc_in     = 1'b1;
               status_in  = ST_IDLE;
               index_in   = '0;
               loop_in    = 1'b0;
               running_in = 1'b0;
            end
            OP_TICK: begin
               acc_in    = running_ff;
               status_in = running_ff ? ST_RUN : ST_IDLE;
               if (running_ff) begin
                  index_in = next_wide[INDEX_WIDTH-1:0];
                  if (clip_end) begin
                     if (loop_ff) begin
                        index_in = '0;
                     end else begin
                        running_in = 1'b0;
                        status_in  = ST_DONE;
                     end
                  end
               end
            end
            default: begin
               acc_in    = 1'b0;
               status_in = running_ff ? ST_RUN : ST_IDLE;
            end
         endcase
      end

      if (cmd.mul_load) begin
         prod_in = PROD_W'(div_rem[POS_W-1:0]) * PROD_W'(freq);
      end

      // A zero rate gives phase zero, which is also the rest value.
      if (cmd.sample_load) begin
         sample_in = sine_value((rate_ff == '0) ? '0 : div_quot[PHASE_W-1:0]);
      end

      if (cmd.interval_load) begin
         if (rate_ff == '0) begin
            interval_in = '0;
         end else if (us_quot > US_W'(INTERVAL_MAX)) begin
            interval_in = INTERVAL_MAX;
         end else begin
            interval_in = us_quot[INTERVAL_W-1:0];
         end
      end

      if (cmd.out_load) begin
         out_in = RSP_W'({interval_ff, sample_ff, status_ff, acc_ff});
      end

      if (csr_we) begin
         case (reg_type'(csr_index))
            REG_RATE:  rate_in  = csr_wdata[RATE_W-1:0];
            REG_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default:   rate_in  = rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RATE_RESET;
         count_ff   <= COUNT_RESET;
         index_ff   <= '0;
         running_ff <= 1'b0;
         loop_ff    <= 1'b0;
      end else begin
         rate_ff    <= rate_in;
         count_ff   <= count_in;
         index_ff   <= index_in;
         running_ff <= running_in;
         loop_ff    <= loop_in;
      end
      acc_ff      <= acc_in;
      status_ff   <= status_in;
      sample_ff   <= sample_in;
      interval_ff <= interval_in;
      prod_ff     <= prod_in;
      out_ff      <= out_in;
   end

   assign stat.run_tick = (op == OP_TICK) && running_ff;
   assign stat.div_busy = div_busy;
   assign rsp_data      = out_ff;

endmodule

// File: hw/rtl/tss_ctrl.sv
// Controller of the tone sequencer: sequences the divisions and the output register.
// Depends on tss_pkg for the command and status structs.
module tss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  tss_pkg::stat_type  stat,
   output tss_pkg::cmd_type   cmd
);
   import tss_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_NOTE   = 7'b0000010,
      S_MUL    = 7'b0000100,
      S_PSTART = 7'b0001000,
      S_PHASE  = 7'b0010000,
      S_INTV   = 7'b0100000,
      S_EMIT   = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           valid_ff, valid_in;
   logic           accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.div_kind      = DIV_NOTE;
      cmd.accept        = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.run_tick) begin
                  cmd.div_start = 1'b1;
                  cmd.div_kind  = DIV_NOTE;
                  state_in      = S_NOTE;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_NOTE: begin
            if (!stat.div_busy) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_PSTART;
         end
         S_PSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_kind  = DIV_PHASE;
            state_in      = S_PHASE;
         end
         S_PHASE: begin
            if (!stat.div_busy) begin
               cmd.sample_load = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_kind    = DIV_INTV;
               state_in        = S_INTV;
            end
         end
         S_INTV: begin
            if (!stat.div_busy) begin
               cmd.interval_load = 1'b1;
               state_in          = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// File: hw/rtl/demo_tone_sample_sequencer_core.sv
// Top level of the eight-note tone sample sequencer.
// Depends on tss_pkg, tss_ctrl, tss_datapath (with tss_div) and assert_macros.svh.
//
// Usage: commands arrive as items on the req_ stream (tuser carries the operation:
// tick, start or stop; tdata bit 0 carries the loop request used by start). Every
// command gives exactly one result item on the rsp_ stream with the accepted flag,
// the status, the 8-bit audio sample and the sample interval in microseconds.
// The csr_ port writes sample_rate (index 0) and sample_count (index 1); write it
// only while no command is in flight.
// Sequencing: a start, stop, idle tick or unused code goes from acceptance straight
// to the emit state. A tick while playing runs three divisions on one serial divider
// (note index, 24 bits; sine phase, 16 bits; frame interval, 20 bits) plus one
// multiply before it reaches the emit state. One item is worked on at a time, so
// no new command is taken until the result is loaded into the output register.
// The result sits in an output register: the next command is taken while it waits,
// and a stalled receiver only holds the block once a second result is ready.
// Reset is synchronous and active high; it stops playback, clears the play index
// and loop flag and restores the rate to 16000 Hz and the clip to 32000 samples.
module demo_tone_sample_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tss_pkg::REQ_DATA_W-1:0] req_tdata,  // [0] loop_request
   input  logic [tss_pkg::OP_W-1:0]      req_tuser,   // [1:0] operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tss_pkg::RSP_W-1:0]     rsp_tdata,   // [0] accepted, [2:1] status,
                                                      // [10:3] audio_sample,
                                                      // [28:11] interval_us
   input  logic                          csr_we,
   input  logic [tss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_W-1:0]     csr_wdata
);
   import tss_pkg::*;

`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   // Handshake and result conditions named for the checks at the end.
   logic req_accept;
   logic rsp_done;
   logic rsp_refused;
   logic rsp_silent;

   // The controller owns the handshakes; the datapath owns all item state.
   tss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tss_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_op    (req_tuser),
      .req_loop  (req_tdata[0]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

   assign req_accept  = req_tvalid && req_tready;
   assign rsp_done    = rsp_tvalid && (rsp_tdata[2:1] == ST_DONE);
   assign rsp_refused = rsp_tvalid && !rsp_tdata[0];
   assign rsp_silent  = (rsp_tdata[28:3] == '0);

   // The block works on one item at a time, so it never takes two in a row.
   `TSS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_accept, !req_tready, "two items in a row")

   // A completed clip is only reported on an accepted tick.
   `TSS_ASSERT_NOW(a_done_accepted, clock, reset, rsp_done, rsp_tdata[0], "done without accept")

   // Refused commands and idle ticks carry neither sample nor interval.
   `TSS_ASSERT_NOW(a_refused_silent, clock, reset, rsp_refused, rsp_silent, "payload on refusal")

endmodule

// File: tb/tb_demo_tone_sample_sequencer_core.sv
// Self-checking testbench for demo_tone_sample_sequencer_core.
// Depends on tss_pkg and the core RTL; it predicts every result item from its own
// model of the melody player and compares each result item field by field.
module tb_demo_tone_sample_sequencer_core;

   import tss_pkg::*;

   // The operation field is two bits wide, but the package names only three codes.
   // The fourth code has no function and must be answered without side effects.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // No command may leave both streams silent for this long. A playing tick runs three
   // serial divisions, and a long stall of the receiver or the sender adds to that.
   localparam int unsigned QUIET_LIMIT = 4000;

   // The predictor keeps its own copy of the sine table (one quarter period, mirrored
   // into a full cycle around mid-scale) and of the eight-note melody.
   localparam logic [6:0] QUARTER_SINE [0:64] = '{
      7'd0,  7'd2,  7'd4,  7'd7,  7'd9,  7'd11, 7'd13, 7'd15,
      7'd18, 7'd20, 7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32,
      7'd34, 7'd36, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46, 7'd48,
      7'd50, 7'd52, 7'd54, 7'd55, 7'd57, 7'd59, 7'd60, 7'd62,
      7'd64, 7'd65, 7'd67, 7'd68, 7'd70, 7'd71, 7'd72, 7'd74,
      7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
      7'd83, 7'd84, 7'd85, 7'd85, 7'd86, 7'd87, 7'd87, 7'd88,
      7'd88, 7'd89, 7'd89, 7'd89, 7'd90, 7'd90, 7'd90, 7'd90,
      7'd90
   };

   localparam logic [9:0] MELODY_HZ [0:7] = '{
      10'd500, 10'd600, 10'd700, 10'd800, 10'd700, 10'd600, 10'd500, 10'd0
   };

   typedef struct packed {
      logic                  accepted;
      logic [STATUS_W-1:0]   status;
      logic [SAMPLE_W-1:0]   sample;
      logic [INTERVAL_W-1:0] interval_us;
   } tone_result_type;

   // Every input of the core starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [0] loop_request
   logic [OP_W-1:0]       req_tuser  = '0;   // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;         // [0] accepted, [2:1] status,
                                             // [10:3] audio_sample, [28:11] interval_us
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   // Predictor state: the player and its two registers, as after reset.
   logic [RATE_W-1:0]      cfg_rate;
   logic [COUNT_W-1:0]     cfg_count;
   logic [INDEX_WIDTH-1:0] play_index;
   logic                   playing;
   logic                   looping;

   // Results predicted at acceptance, waiting for the core to produce them.
   tone_result_type due_results [$];

   int unsigned send_idle_pct = 28;
   int unsigned recv_idle_pct = 84;
   int unsigned quiet_cycles  = 0;
   int unsigned mismatches    = 0;
   int unsigned items_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned starts_taken  = 0;
   int unsigned clips_ended   = 0;
   int unsigned loop_wraps    = 0;
   int unsigned settings_used = 0;

   demo_tone_sample_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // One full sine period of 256 steps, built by mirroring the quarter table.
   function automatic logic [7:0] sine_level(input logic [7:0] phase);
      logic [6:0] m;
      logic [7:0] v;
      m = phase[6:0];
      v = (m <= 7'd64) ? 8'(QUARTER_SINE[m]) : 8'(QUARTER_SINE[128 - m]);
      return phase[7] ? (8'd128 - v) : (8'd128 + v);
   endfunction

   // Sample for one position in the clip. Each note lasts a quarter of the rate in
   // samples (at least one sample), and the phase within the note is worked out in
   // 64 bits so that no product wraps. The rest note sits at mid-scale.
   function automatic logic [7:0] melody_sample(input longint unsigned idx);
      longint unsigned per_note;
      longint unsigned pos;
      longint unsigned phase;
      logic [9:0]      hz;
      per_note = cfg_rate / 4;
      if (per_note == 0)
         per_note = 1;
      hz = MELODY_HZ[(idx / per_note) % 8];
      if (hz == 0)
         return 8'd128;
      pos   = idx % per_note;
      phase = 0;
      if (cfg_rate != 0)
         phase = (pos * hz * 256) / cfg_rate;
      return sine_level(phase[7:0]);
   endfunction

   // Applies one command to the predicted player and returns the result it causes.
   function automatic tone_result_type sequence_command(input logic [OP_W-1:0] op,
                                                        input logic loop_req);
      tone_result_type r;
      longint unsigned next_index;
      longint unsigned span;
      r = '0;
      case (op)
         OP_START: begin
            // A start is refused while either register is zero; the player keeps
            // whatever it was doing, and the status shows it.
            if (cfg_count != 0 && cfg_rate != 0) begin
               play_index = '0;
               looping    = loop_req;
               playing    = 1'b1;
               r.accepted = 1'b1;
               starts_taken++;
            end
            r.status = playing ? ST_RUN : ST_IDLE;
         end
         OP_STOP: begin
            play_index = '0;
            looping    = 1'b0;
            playing    = 1'b0;
            r.accepted = 1'b1;
            r.status   = ST_IDLE;
         end
         OP_TICK: begin
            // An idle tick leaves every field at zero.
            if (playing) begin
               r.accepted = 1'b1;
               r.status   = ST_RUN;
               r.sample   = melody_sample(play_index);
               if (cfg_rate != 0) begin
                  span = 1000000 / cfg_rate;
                  r.interval_us = (span > INTERVAL_MAX) ? INTERVAL_MAX : span[INTERVAL_W-1:0];
               end
               next_index = play_index + 1;
               if (next_index >= cfg_count) begin
                  if (looping) begin
                     next_index = 0;
                     loop_wraps++;
                  end else begin
                     playing  = 1'b0;
                     r.status = ST_DONE;
                     clips_ended++;
                  end
               end
               play_index = next_index[INDEX_WIDTH-1:0];
            end
         end
         default: begin
            r.status = playing ? ST_RUN : ST_IDLE;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------

   function automatic void check_field(input string field_name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
      end
   endfunction

   // Every result item taken from the core is matched with the oldest prediction.
   always @(posedge clock) begin : result_check
      tone_result_type seen;
      tone_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         seen.accepted    = rsp_tdata[0];
         seen.status      = rsp_tdata[2:1];
         seen.sample      = rsp_tdata[10:3];
         seen.interval_us = rsp_tdata[28:11];
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing, got %h",
                     $time, rsp_tdata);
         end else begin
            want = due_results.pop_front();
            check_field("accepted", want.accepted, seen.accepted);
            check_field("status", want.status, seen.status);
            check_field("audio_sample", want.sample, seen.sample);
            check_field("interval_us", want.interval_us, seen.interval_us);
         end
      end
   end

   // The receiver holds off at random in the share of cycles that the current
   // phase of the run asks for.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Watchdog: a run in which nothing moves for too long has hung.
   always @(posedge clock)
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: nothing moved for %0d cycles, %0d results still due",
               $time, QUIET_LIMIT, due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Sends one command item and records its predicted result at acceptance. The
   // valid line is only lowered inside an idle gap, so a back-to-back item never
   // sees valid dropped and raised in the same time step.
   task automatic send_command(input logic [OP_W-1:0] op, input logic loop_req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, loop_req};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      due_results.push_back(sequence_command(op, loop_req));
      items_sent++;
   endtask

   // Holds the sender back until every predicted result has come out. Each command
   // gives a result, so an empty store means the core is idle; a few more cycles
   // let the output register settle before any register write.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register; the caller has drained the core first.
   task automatic write_reg(input reg_type idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_RATE)
         cfg_rate = value[RATE_W-1:0];
      else
         cfg_count = value[COUNT_W-1:0];
   endtask

   task automatic set_config(input logic [CSR_W-1:0] rate_word,
                             input logic [CSR_W-1:0] count_word);
      drain_results();
      write_reg(REG_RATE, rate_word);
      write_reg(REG_COUNT, count_word);
      settings_used++;
   endtask

   // Picks a rate and clip length. Most settings are small, so that a run of ticks
   // crosses notes, reaches the clip end and wraps; a few are huge or at the
   // extremes of the registers, including rates the core must treat specially.
   task automatic pick_random_config();
      int unsigned sel;
      logic [CSR_W-1:0] rate_word;
      logic [CSR_W-1:0] count_word;
      sel = $urandom_range(99);
      if (sel < 55) begin
         rate_word  = CSR_W'($urandom_range(4, 48));
         count_word = CSR_W'($urandom_range(1, 2 * rate_word + 8));
      end else if (sel < 75) begin
         rate_word  = CSR_W'($urandom_range(49, 2000));
         count_word = CSR_W'($urandom_range(1, 120));
      end else if (sel < 87) begin
         rate_word  = CSR_W'($urandom_range(4, 96000));
         count_word = CSR_W'($urandom_range(1, 24'hFFFFFF));
      end else begin
         case ($urandom_range(5))
            0:       rate_word = '0;
            1:       rate_word = CSR_W'($urandom_range(1, 3));
            2:       rate_word = CSR_W'({RATE_W{1'b1}});
            // Bits above the rate field must be dropped by the core.
            3:       rate_word = {7'($urandom_range(1, 127)), 17'($urandom_range(4, 60))};
            default: rate_word = CSR_W'(96000);
         endcase
         case ($urandom_range(3))
            0:       count_word = '0;
            1:       count_word = CSR_W'(1);
            2:       count_word = 24'hFFFFFF;
            default: count_word = CSR_W'($urandom_range(2, 30));
         endcase
      end
      set_config(rate_word, count_word);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Straight after reset nothing plays: a tick gives zeros, the unused code is
   // answered but refused, and a stop is always taken.
   task automatic test_idle_commands();
      send_command(OP_TICK, 1'b1);
      send_command(OP_UNUSED, 1'b1);
      send_command(OP_STOP, 1'b0);
   endtask

   // At the reset rate and clip length: start once, tick, try the unused code while
   // playing, restart with looping and stop.
   task automatic test_start_and_restart();
      send_command(OP_START, 1'b0);
      send_command(OP_TICK, 1'b0);
      send_command(OP_UNUSED, 1'b0);
      send_command(OP_START, 1'b1);
      send_command(OP_STOP, 1'b1);
   endtask

   // A start is refused with an empty clip and again with a zero rate.
   task automatic test_start_refused();
      drain_results();
      write_reg(REG_COUNT, 24'd0);
      send_command(OP_START, 1'b1);
      drain_results();
      write_reg(REG_COUNT, 24'd1);
      write_reg(REG_RATE, 24'd0);
      send_command(OP_START, 1'b0);
   endtask

   // A one-sample clip played once: the first tick ends it, the next is idle.
   task automatic test_clip_end();
      drain_results();
      write_reg(REG_RATE, 24'd4);
      send_command(OP_START, 1'b0);
      send_command(OP_TICK, 1'b1);
      send_command(OP_TICK, 1'b0);
   endtask

   // At the lowest usable rate each note lasts one sample, so eight ticks walk the
   // whole melody including the rest. The clip is as long as the register allows.
   task automatic test_full_melody();
      drain_results();
      write_reg(REG_COUNT, 24'hFFFFFF);
      send_command(OP_START, 1'b1);
      repeat (8) send_command(OP_TICK, 1'b0);
   endtask

   // The rate changes under a playing clip: zero gives a zero interval and phase,
   // one makes the interval saturate, and the largest rate gives the shortest one.
   task automatic test_rate_extremes();
      drain_results();
      write_reg(REG_RATE, 24'd0);
      send_command(OP_TICK, 1'b0);
      drain_results();
      write_reg(REG_RATE, 24'd1);
      send_command(OP_TICK, 1'b0);
      drain_results();
      write_reg(REG_RATE, 24'(17'h1FFFF));
      send_command(OP_TICK, 1'b0);
      send_command(OP_STOP, 1'b0);
   endtask

   // Random playback under one pacing of the two streams. Most of it is a start
   // with random looping followed by a run of ticks, now and then cut by a stop;
   // the rest is noise made of any code with any loop bit. A run of ticks ends
   // early once the item quota of this pacing is reached.
   task automatic test_random_playback(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned quota);
      int unsigned first_item;
      int unsigned run_len;
      int unsigned k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first_item    = items_sent;
      while (items_sent - first_item < quota) begin
         pick_random_config();
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(99) < 12) begin
               repeat ($urandom_range(1, 6))
                  send_command(OP_W'($urandom_range(3)), 1'($urandom_range(1)));
            end else begin
               send_command(OP_START, 1'($urandom_range(1)));
               run_len = $urandom_range(1, (cfg_count < 87) ? cfg_count + 3 : 90);
               for (k = 0; (k < run_len) && (items_sent - first_item < quota); k++) begin
                  if ($urandom_range(99) == 0)
                     send_command(OP_STOP, 1'($urandom_range(1)));
                  else
                     send_command(OP_TICK, 1'($urandom_range(1)));
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Run sequence
   // ---------------------------------------------------------------------------

   initial begin
      // The predictor starts from the reset state of the core.
      cfg_rate   = RATE_RESET;
      cfg_count  = COUNT_RESET;
      play_index = '0;
      playing    = 1'b0;
      looping    = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The directed tests run under the first pacing: a sender that idles a little
      // and a receiver that mostly stalls.
      test_idle_commands();
      test_start_and_restart();
      test_start_refused();
      test_clip_end();
      test_full_melody();
      test_rate_extremes();

      test_random_playback(28, 84, 375);
      test_random_playback(84, 28, 375);
      test_random_playback(0, 0, 375);

      // Let the last results drain, then keep the clock running for longer than a playing
      // tick takes, in case anything unexpected is still on its way out.
      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Covered %0d commands and checked %0d results over %0d register settings.",
               items_sent, results_seen, settings_used);
      $display("Playback: %0d starts taken, %0d clips played out, %0d loop wraps.",
               starts_taken, clips_ended, loop_wraps);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tss_pkg.sv
hw/rtl/tss_div.sv
hw/rtl/tss_datapath.sv
hw/rtl/tss_ctrl.sv
hw/rtl/demo_tone_sample_sequencer_core.sv
tb/tb_demo_tone_sample_sequencer_core.sv
